// ===== design/kmsd_pkg.sv =====
package kmsd_pkg;

  localparam int ROWS_DEF      = 5;
  localparam int COLS_DEF      = 4;
  localparam int MAP_BANKS_DEF = 2;

  localparam int ROW_W    = 3;
  localparam int COL_W    = 2;
  localparam int CODE_W   = 8;
  localparam int CNT_W    = 7;
  localparam int KIND_W   = 2;
  localparam int COL_BITS = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // At most this many results leave for one scan tick.
  localparam int MAX_EVENTS = 4;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 7'd20;
  localparam logic [CNT_W-1:0] THRESH_MIN     = 7'd1;
  localparam logic [CNT_W-1:0] THRESH_MAX     = 7'd126;

  localparam logic OP_SCAN      = 1'b0;
  localparam logic OP_MAP_WRITE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_BANK = 2'd1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] drive;
  } scan_info_t;

endpackage

// ===== design/keypad_matrix_scan_debounce.sv =====
// Matrix keypad scanner with per-key debounce.
// Input stream (s_axis): tuser selects a scan tick or a key map write; a
// tick carries the sampled column bits of the driven row. Every second tick
// samples: one lane per column steps that key's counter, and the drive
// moves down one row (wrapping from row 0 to the top row).
// Output stream (m_axis): one result per press or release event, lowest
// column first, up to four per tick, tlast on the final one. A request that
// causes no event gives one result with kind zero and tlast set. Every
// result shows the row now driven.
// Config channel: index 0 sets the debounce threshold, index 1 the map bank.
// Write it only while the block is idle; it is always ready.
// Results are registered: a request goes to the event buffer, and each
// result then to the output register. Throughput: one request per cycle
// while each gives a single result and the receiver keeps up; a tick with
// k events holds the buffer until all leave, one per cycle while taken.
// Reset clears all counters and key map entries (they read as zero), drives
// the top row and loads a threshold of 20 with bank 0.
// When the receiver stalls, the output register holds its result, the event
// buffer holds the rest, and s_axis_tready drops once the buffer is full.
module keypad_matrix_scan_debounce #(
  parameter int ROWS      = kmsd_pkg::ROWS_DEF,
  parameter int COLS      = kmsd_pkg::COLS_DEF,
  parameter int MAP_BANKS = kmsd_pkg::MAP_BANKS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // column_bits[3:0], entry_row[6:4], entry_col[8:7], entry_code[16:9]
  input  logic [23:0]                         s_axis_tdata,
  // op
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // event_row[2:0], event_col[4:3], event_code[12:5], drive_row[15:13]
  output logic [15:0]                         m_axis_tdata,
  // event_kind
  output logic [kmsd_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kmsd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import kmsd_pkg::*;

  localparam int BANK_W = (MAP_BANKS > 1) ? $clog2(MAP_BANKS) : 1;

  logic [COL_BITS-1:0] column_bits;
  logic [ROW_W-1:0]    entry_row;
  logic [COL_W-1:0]    entry_col;
  logic [CODE_W-1:0]   entry_code;

  logic [CNT_W-1:0]  debounce_q;
  logic [BANK_W-1:0] bank_q;
  logic [ROW_W-1:0]  scan_row_q, scan_row_d, drive;
  logic              phase_q;
  logic [CNT_W-1:0]  thresh;

  logic accept, tick, sample, map_wr;
  logic [COLS-1:0] press, release_ev;
  logic [COLS*CODE_W-1:0] codes;
  logic [COLS-1:0] codes_valid;
  scan_info_t info;

  logic [KIND_W-1:0] out_kind;
  logic [ROW_W-1:0]  out_row, out_drive;
  logic [COL_W-1:0]  out_col;
  logic [CODE_W-1:0] out_code;

  assign column_bits = s_axis_tdata[3:0];
  assign entry_row   = s_axis_tdata[6:4];
  assign entry_col   = s_axis_tdata[8:7];
  assign entry_code  = s_axis_tdata[16:9];

  assign accept = s_axis_tvalid && s_axis_tready;
  assign tick   = accept && (s_axis_tuser == OP_SCAN);
  assign sample = tick && !phase_q;
  assign map_wr = accept && (s_axis_tuser == OP_MAP_WRITE)
                  && (32'(entry_row) < ROWS) && (32'(entry_col) < COLS);

  always_comb begin
    if (debounce_q == '0) begin
      thresh = THRESH_MIN;
    end else if (debounce_q > THRESH_MAX) begin
      thresh = THRESH_MAX;
    end else begin
      thresh = debounce_q;
    end
  end

  assign scan_row_d = (scan_row_q == '0) ? ROW_W'(ROWS - 1) : scan_row_q - 1'b1;
  assign drive      = sample ? scan_row_d : scan_row_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      bank_q     <= '0;
      scan_row_q <= ROW_W'(ROWS - 1);
      phase_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_DEBOUNCE: debounce_q <= cfg_data_i;
          REG_MAP_BANK: begin
            if (32'(cfg_data_i[0]) < MAP_BANKS) begin
              bank_q <= BANK_W'(cfg_data_i[0]);
            end
          end
          default: ;
        endcase
      end
      if (tick) begin
        phase_q <= !phase_q;
      end
      if (sample) begin
        scan_row_q <= scan_row_d;
      end
    end
  end

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic pressed;
    if (c < COL_BITS) begin : g_bit
      assign pressed = column_bits[c];
    end else begin : g_none
      assign pressed = 1'b0;
    end
    kmsd_lane #(
      .ROWS(ROWS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sample_i (sample),
      .row_i    (scan_row_q),
      .pressed_i(pressed),
      .thresh_i (thresh),
      .press_o  (press[c]),
      .release_o(release_ev[c])
    );
  end

  kmsd_keymap #(
    .ROWS     (ROWS),
    .COLS     (COLS),
    .MAP_BANKS(MAP_BANKS),
    .BANK_W   (BANK_W)
  ) u_keymap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (map_wr),
    .wr_bank_i (bank_q),
    .wr_row_i  (entry_row),
    .wr_col_i  (entry_col),
    .wr_code_i (entry_code),
    .rd_en_i   (accept),
    .rd_bank_i (bank_q),
    .rd_row_i  (scan_row_q),
    .rd_code_o (codes),
    .rd_valid_o(codes_valid)
  );

  assign info.row   = scan_row_q;
  assign info.drive = drive;

  kmsd_merge #(
    .COLS(COLS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .info_i      (info),
    .press_i     (press),
    .release_i   (release_ev),
    .code_i      (codes),
    .code_valid_i(codes_valid),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_code_o  (out_code),
    .out_drive_o (out_drive),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_drive, out_code, out_col, out_row};
  assign m_axis_tuser = out_kind;

endmodule

// ===== design/kmsd_lane.sv =====
module kmsd_lane #(
  parameter int ROWS = kmsd_pkg::ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sample_i,
  input  logic [kmsd_pkg::ROW_W-1:0] row_i,
  input  logic                       pressed_i,
  input  logic [kmsd_pkg::CNT_W-1:0] thresh_i,
  output logic                       press_o,
  output logic                       release_o
);
  import kmsd_pkg::*;

  localparam int ROW_IW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [CNT_W-1:0] cnt_q [ROWS];
  logic [CNT_W-1:0] cnt_d;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] inc;
  logic [ROW_IW-1:0] idx;
  logic press, rel;

  assign idx = row_i[ROW_IW-1:0];

  // Counter runs 0..T-1 while held down, sits at T+1 once pressed; any
  // sample with the key up returns it to zero.
  always_comb begin
    cnt   = cnt_q[idx];
    inc   = (cnt < thresh_i) ? cnt + 1'b1 : cnt;
    press = pressed_i && (inc == thresh_i);
    rel   = !pressed_i && (cnt >= thresh_i);
    if (!pressed_i) begin
      cnt_d = '0;
    end else if (press) begin
      cnt_d = thresh_i + 1'b1;
    end else begin
      cnt_d = inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        cnt_q[r] <= '0;
      end
    end else if (sample_i) begin
      cnt_q[idx] <= cnt_d;
    end
  end

  assign press_o   = sample_i && press;
  assign release_o = sample_i && rel;

endmodule

// ===== design/kmsd_keymap.sv =====
module kmsd_keymap #(
  parameter int ROWS      = kmsd_pkg::ROWS_DEF,
  parameter int COLS      = kmsd_pkg::COLS_DEF,
  parameter int MAP_BANKS = kmsd_pkg::MAP_BANKS_DEF,
  parameter int BANK_W    = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [BANK_W-1:0]                wr_bank_i,
  input  logic [kmsd_pkg::ROW_W-1:0]       wr_row_i,
  input  logic [kmsd_pkg::COL_W-1:0]       wr_col_i,
  input  logic [kmsd_pkg::CODE_W-1:0]      wr_code_i,
  input  logic                             rd_en_i,
  input  logic [BANK_W-1:0]                rd_bank_i,
  input  logic [kmsd_pkg::ROW_W-1:0]       rd_row_i,
  output logic [COLS*kmsd_pkg::CODE_W-1:0] rd_code_o,
  output logic [COLS-1:0]                  rd_valid_o
);
  import kmsd_pkg::*;

  localparam int DEPTH  = MAP_BANKS * ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_IW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int PROD_W = BANK_W + ROW_W + 4;

  // One word per bank and row, one byte lane per column.
  logic [COLS*CODE_W-1:0] mem_q [DEPTH];
  logic [COLS-1:0]        valid_q [DEPTH];
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [COL_IW-1:0]      wcol;

  assign waddr = ADDR_W'(PROD_W'(wr_bank_i) * PROD_W'(ROWS) + PROD_W'(wr_row_i));
  assign raddr = ADDR_W'(PROD_W'(rd_bank_i) * PROD_W'(ROWS) + PROD_W'(rd_row_i));
  assign wcol  = COL_IW'(wr_col_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[waddr][wcol*CODE_W +: CODE_W] <= wr_code_i;
    end
    if (rd_en_i) begin
      rd_code_o <= mem_q[raddr];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < DEPTH; a++) begin
        valid_q[a] <= '0;
      end
      rd_valid_o <= '0;
    end else begin
      if (wr_en_i) begin
        valid_q[waddr][wcol] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_o <= valid_q[raddr];
      end
    end
  end

endmodule

// ===== design/kmsd_merge.sv =====
module kmsd_merge #(
  parameter int COLS = kmsd_pkg::COLS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  kmsd_pkg::scan_info_t             info_i,
  input  logic [COLS-1:0]                  press_i,
  input  logic [COLS-1:0]                  release_i,
  input  logic [COLS*kmsd_pkg::CODE_W-1:0] code_i,
  input  logic [COLS-1:0]                  code_valid_i,
  output logic                             ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kmsd_pkg::KIND_W-1:0]      out_kind_o,
  output logic [kmsd_pkg::ROW_W-1:0]       out_row_o,
  output logic [kmsd_pkg::COL_W-1:0]       out_col_o,
  output logic [kmsd_pkg::CODE_W-1:0]      out_code_o,
  output logic [kmsd_pkg::ROW_W-1:0]       out_drive_o,
  output logic                             out_last_o
);
  import kmsd_pkg::*;

  localparam int COL_IW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int NUM_W  = $clog2(MAX_EVENTS);
  localparam logic [NUM_W-1:0] NUM_LAST = NUM_W'(MAX_EVENTS - 1);

  logic              e_valid_q;
  logic [COLS-1:0]   pend_q, kind_q;
  scan_info_t        info_q;
  logic [NUM_W-1:0]  num_q;

  logic              emit, any, last;
  logic [COL_IW-1:0] sel;
  logic [COLS-1:0]   rest;

  logic [KIND_W-1:0] kind_d;
  logic [ROW_W-1:0]  row_d;
  logic [COL_W-1:0]  col_d;
  logic [CODE_W-1:0] code_d;

  // Lowest pending column goes first.
  always_comb begin
    sel = '0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (pend_q[c]) begin
        sel = COL_IW'(c);
      end
    end
    any  = |pend_q;
    rest = pend_q;
    rest[sel] = 1'b0;
    last = !any || (rest == '0) || (num_q == NUM_LAST);
  end

  assign emit    = e_valid_q && (!out_valid_o || out_ready_i);
  assign ready_o = !e_valid_q || (emit && last);

  always_comb begin
    kind_d = KIND_NONE;
    row_d  = '0;
    col_d  = '0;
    code_d = '0;
    if (any) begin
      kind_d = kind_q[sel] ? KIND_PRESS : KIND_RELEASE;
      row_d  = info_q.row;
      col_d  = COL_W'(sel);
      code_d = code_valid_i[sel] ? code_i[sel*CODE_W +: CODE_W] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      pend_q      <= '0;
      num_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (load_i) begin
        e_valid_q <= 1'b1;
        pend_q    <= press_i | release_i;
        num_q     <= '0;
      end else if (emit) begin
        pend_q <= rest;
        num_q  <= num_q + 1'b1;
        if (last) begin
          e_valid_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= press_i;
      info_q <= info_i;
    end
    if (emit) begin
      out_kind_o  <= kind_d;
      out_row_o   <= row_d;
      out_col_o   <= col_d;
      out_code_o  <= code_d;
      out_drive_o <= info_q.drive;
      out_last_o  <= last;
    end
  end

endmodule
